### src/smas_pkg.sv
// Shared types and constants for the sorted multi-alarm scheduler.
// No dependencies; used by sma_cell, sma_chain and the top level.
package smas_pkg;

	// Default sizes, handed down as top-level parameter defaults
	localparam int MAX_ALARMS_DEF = 16;
	localparam int TIME_BITS_DEF  = 64;

	// Alarm identifiers are fixed by the 4-bit alarm_id field
	localparam int ID_W    = 4;
	localparam int NUM_IDS = 16;

	// Operation codes
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_ARM    = 2'd1;
	localparam logic [1:0] OP_CANCEL = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	// Input item
	typedef struct packed {
		logic [1:0]      operation;
		logic [ID_W-1:0] alarm_id;
		logic [63:0]     interval_clocks;
		logic            repeat_req;
	} item_t;

	// Result item
	typedef struct packed {
		logic            fired;
		logic [ID_W-1:0] fired_alarm;
		logic            status;
		logic [4:0]      active_count;
		logic [63:0]     next_deadline;
	} result_t;

	// What every cell of the sorted list does this cycle
	typedef enum logic [1:0] {
		CM_HOLD,
		CM_REMOVE,
		CM_INSERT
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t      mode;
		logic [ID_W-1:0] id;
	} cell_ctl_t;

endpackage

### src/sma_cell.sv
// One slot of the deadline-sorted alarm list.
// Depends on smas_pkg; instantiated in a row by sma_chain.
module sma_cell #(
	parameter int TIME_BITS = smas_pkg::TIME_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  smas_pkg::cell_ctl_t     ctl,
	input  logic [TIME_BITS-1:0]    new_dl,
	// removal: some cell left of here (in) or at or left of here (out) matched
	input  logic                    kill_in,
	output logic                    kill_out,
	// insertion: left neighbor is empty or its deadline is at or past the new one
	input  logic                    ge_in,
	output logic                    ge_out,
	// left neighbor's entry (shift right on insert)
	input  logic                    left_valid,
	input  logic [smas_pkg::ID_W-1:0] left_id,
	input  logic [TIME_BITS-1:0]    left_dl,
	// right neighbor's entry (shift left on remove)
	input  logic                    right_valid,
	input  logic [smas_pkg::ID_W-1:0] right_id,
	input  logic [TIME_BITS-1:0]    right_dl,
	// this slot
	output logic                    valid,
	output logic [smas_pkg::ID_W-1:0] id,
	output logic [TIME_BITS-1:0]    deadline
);

	logic                      valid_q;
	logic [smas_pkg::ID_W-1:0] id_q;
	logic [TIME_BITS-1:0]      dl_q;
	logic                      hit;
	logic                      ge;
	logic                      take_left;
	logic                      take_right;
	logic                      take_new;

	// Local decisions; removal kill flag ripples along the row
	assign hit      = valid_q && (id_q == ctl.id);
	assign kill_out = kill_in | hit;
	assign ge       = !valid_q || (dl_q >= new_dl);
	assign ge_out   = ge;

	assign take_right = (ctl.mode == smas_pkg::CM_REMOVE) && kill_out;
	assign take_left  = (ctl.mode == smas_pkg::CM_INSERT) && ge_in;
	assign take_new   = (ctl.mode == smas_pkg::CM_INSERT) && ge && !ge_in;

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_right) begin
			valid_q <= right_valid;
		end else if (take_left) begin
			valid_q <= left_valid;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end
	end

	// Entry payload
	always_ff @(posedge clk) begin
		if (take_right) begin
			id_q <= right_id;
			dl_q <= right_dl;
		end else if (take_left) begin
			id_q <= left_id;
			dl_q <= left_dl;
		end else if (take_new) begin
			id_q <= ctl.id;
			dl_q <= new_dl;
		end
	end

	assign valid    = valid_q;
	assign id       = id_q;
	assign deadline = dl_q;

endmodule

### src/sma_chain.sv
// Row of sma_cell slots forming the sorted alarm list, head at slot zero.
// Depends on smas_pkg and sma_cell.
module sma_chain #(
	parameter int MAX_ALARMS = smas_pkg::MAX_ALARMS_DEF,
	parameter int TIME_BITS  = smas_pkg::TIME_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  smas_pkg::cell_ctl_t       ctl,
	input  logic [TIME_BITS-1:0]      new_dl,
	output logic                      head_valid,
	output logic [smas_pkg::ID_W-1:0] head_id,
	output logic [TIME_BITS-1:0]      head_dl,
	output logic [MAX_ALARMS-1:0]     valids
);

	logic [MAX_ALARMS-1:0]      kill;
	logic [MAX_ALARMS-1:0]      ge;
	logic [MAX_ALARMS-1:0]      v;
	logic [smas_pkg::ID_W-1:0]  ids [MAX_ALARMS];
	logic [TIME_BITS-1:0]       dls [MAX_ALARMS];

	// Neighbor wiring; ends see an empty entry, and the first cell sees no kill or ge flag
	for (genvar k = 0; k < MAX_ALARMS; k++) begin : g_cell
		logic                      kin;
		logic                      gin;
		logic                      lv;
		logic [smas_pkg::ID_W-1:0] lid;
		logic [TIME_BITS-1:0]      ldl;
		logic                      rv;
		logic [smas_pkg::ID_W-1:0] rid;
		logic [TIME_BITS-1:0]      rdl;

		if (k == 0) begin : g_first
			assign kin = 1'b0;
			assign gin = 1'b0;
			assign lv  = 1'b0;
			assign lid = '0;
			assign ldl = '0;
		end else begin : g_mid
			assign kin = kill[k-1];
			assign gin = ge[k-1];
			assign lv  = v[k-1];
			assign lid = ids[k-1];
			assign ldl = dls[k-1];
		end

		if (k == MAX_ALARMS-1) begin : g_last
			assign rv  = 1'b0;
			assign rid = '0;
			assign rdl = '0;
		end else begin : g_inner
			assign rv  = v[k+1];
			assign rid = ids[k+1];
			assign rdl = dls[k+1];
		end

		sma_cell #(
			.TIME_BITS(TIME_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.new_dl      (new_dl),
			.kill_in     (kin),
			.kill_out    (kill[k]),
			.ge_in       (gin),
			.ge_out      (ge[k]),
			.left_valid  (lv),
			.left_id     (lid),
			.left_dl     (ldl),
			.right_valid (rv),
			.right_id    (rid),
			.right_dl    (rdl),
			.valid       (v[k]),
			.id          (ids[k]),
			.deadline    (dls[k])
		);
	end

	assign head_valid = v[0];
	assign head_id    = ids[0];
	assign head_dl    = dls[0];
	assign valids     = v;

endmodule

### src/sorted_multi_alarm_scheduler.sv
// Sorted multi-alarm scheduler: time counter, per-alarm settings and control.
// Depends on smas_pkg and sma_chain (which uses sma_cell).
//
// An item is taken when start is high and busy is low; its one result shows on
// result for the single cycle that done is high, and the receiver cannot stall
// it. A tick without re-arm, a cancel, a rejected arm or a no-op goes through
// the removal state only; an arm that enters the list and a tick that fires a
// periodic alarm go through the removal state and then the insertion state.
// busy drops in the done cycle, so a new item is taken only once the last is
// done. The list is a row of cells that does one removal pass and then one
// insertion pass, each shifting entries between neighbors; the insertion pass
// also forms the new deadline as one add feeding the cell compares.
module sorted_multi_alarm_scheduler #(
	parameter int MAX_ALARMS = smas_pkg::MAX_ALARMS_DEF,
	parameter int TIME_BITS  = smas_pkg::TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  smas_pkg::item_t   item,
	output logic              done,
	output smas_pkg::result_t result
);

	localparam int CW = $clog2(MAX_ALARMS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_INSERT
	} state_t;

	state_t                       state_q;
	smas_pkg::item_t              item_q;
	logic [TIME_BITS-1:0]         now_q;
	logic [CW-1:0]                count_q;
	logic [smas_pkg::NUM_IDS-1:0] active_q;
	logic [smas_pkg::NUM_IDS-1:0] repeat_q;
	logic [TIME_BITS-1:0]         intv_q [smas_pkg::NUM_IDS];
	logic                         done_q;
	logic                         fired_q;
	logic [smas_pkg::ID_W-1:0]    fid_q;
	logic                         status_q;

	smas_pkg::cell_ctl_t          ctl;
	logic [TIME_BITS-1:0]         new_dl;
	logic                         head_valid;
	logic [smas_pkg::ID_W-1:0]    head_id;
	logic [TIME_BITS-1:0]         head_dl;
	logic [MAX_ALARMS-1:0]        valids;

	logic [TIME_BITS-1:0]         now_inc;
	logic                         due;
	logic                         is_arm;
	logic                         id_active;
	logic [CW-1:0]                cnt_after;
	logic [smas_pkg::ID_W-1:0]    ins_id;
	logic [TIME_BITS-1:0]         ins_intv;

	// Tick: advance time, head fires if its deadline is reached
	assign now_inc   = now_q + TIME_BITS'(1);
	assign due       = head_valid && (head_dl <= now_inc);
	assign is_arm    = (item_q.operation == smas_pkg::OP_ARM);
	assign id_active = active_q[item_q.alarm_id];
	assign cnt_after = count_q - CW'(id_active);

	// Insertion: arm uses the item, periodic re-arm uses the stored period
	assign ins_id   = is_arm ? item_q.alarm_id : fid_q;
	assign ins_intv = is_arm ? item_q.interval_clocks[TIME_BITS-1:0] : intv_q[fid_q];
	assign new_dl   = now_q + ins_intv;

	// Command to the cell row
	always_comb begin
		ctl.mode = smas_pkg::CM_HOLD;
		ctl.id   = item_q.alarm_id;
		unique case (state_q)
			ST_REMOVE: begin
				if (item_q.operation == smas_pkg::OP_TICK) begin
					ctl.id = head_id;
					if (due) ctl.mode = smas_pkg::CM_REMOVE;
				end else if (is_arm || item_q.operation == smas_pkg::OP_CANCEL) begin
					if (id_active) ctl.mode = smas_pkg::CM_REMOVE;
				end
			end
			ST_INSERT: begin
				ctl.mode = smas_pkg::CM_INSERT;
				ctl.id   = ins_id;
			end
			default: begin
				ctl.mode = smas_pkg::CM_HOLD;
			end
		endcase
	end

	sma_chain #(
		.MAX_ALARMS(MAX_ALARMS),
		.TIME_BITS (TIME_BITS)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.new_dl     (new_dl),
		.head_valid (head_valid),
		.head_id    (head_id),
		.head_dl    (head_dl),
		.valids     (valids)
	);

	// Item capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) item_q <= item;
	end

	// Stored periods, written by every arm
	always_ff @(posedge clk) begin
		if (state_q == ST_REMOVE && is_arm)
			intv_q[item_q.alarm_id] <= item_q.interval_clocks[TIME_BITS-1:0];
	end

	// Sequencer, time, counts, per-alarm flags and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			now_q    <= '0;
			count_q  <= '0;
			active_q <= '0;
			repeat_q <= '0;
			done_q   <= 1'b0;
			fired_q  <= 1'b0;
			fid_q    <= '0;
			status_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						fired_q  <= 1'b0;
						fid_q    <= '0;
						status_q <= 1'b0;
						state_q  <= ST_REMOVE;
					end
				end
				ST_REMOVE: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					case (item_q.operation)
						smas_pkg::OP_TICK: begin
							now_q <= now_inc;
							if (due) begin
								fired_q           <= 1'b1;
								fid_q             <= head_id;
								active_q[head_id] <= 1'b0;
								count_q           <= count_q - CW'(1);
								if (repeat_q[head_id]) begin
									state_q <= ST_INSERT;
									done_q  <= 1'b0;
								end
							end
						end
						smas_pkg::OP_ARM: begin
							active_q[item_q.alarm_id] <= 1'b0;
							repeat_q[item_q.alarm_id] <= item_q.repeat_req;
							count_q                   <= cnt_after;
							if (cnt_after >= CW'(MAX_ALARMS)) begin
								status_q <= 1'b1;
							end else begin
								state_q <= ST_INSERT;
								done_q  <= 1'b0;
							end
						end
						smas_pkg::OP_CANCEL: begin
							active_q[item_q.alarm_id] <= 1'b0;
							count_q                   <= cnt_after;
						end
						default: begin
							count_q <= count_q;
						end
					endcase
				end
				ST_INSERT: begin
					active_q[ins_id] <= 1'b1;
					count_q          <= count_q + CW'(1);
					state_q          <= ST_IDLE;
					done_q           <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Ports
	assign busy                 = (state_q != ST_IDLE);
	assign done                 = done_q;
	assign result.fired         = fired_q;
	assign result.fired_alarm   = fid_q;
	assign result.status        = status_q;
	assign result.active_count  = 5'(count_q);
	assign result.next_deadline = head_valid ? 64'(head_dl) : 64'd0;

	// Checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_count_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valids) == int'(count_q))
		else $error("list count disagrees with occupied cells");

	a_count_active: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(active_q) == int'(count_q))
		else $error("active flags disagree with list count");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ALARMS))
		else $error("list count beyond capacity");

	a_fire_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.fired) |-> !result.status)
		else $error("fire and full status in one result");

endmodule

### verif/tb_sorted_multi_alarm_scheduler.sv
// Testbench for sorted_multi_alarm_scheduler: directed and random arm, cancel and tick items.
// Carries its own scoreboard model of the deadline-sorted alarm list.
// Depends on smas_pkg and the scheduler RTL.
module tb_sorted_multi_alarm_scheduler;

	localparam int RANDOM_ITEMS = 1850;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 8;

	localparam int ID_W      = smas_pkg::ID_W;
	localparam int NUM_IDS   = smas_pkg::NUM_IDS;
	localparam int MAX_SLOTS = smas_pkg::MAX_ALARMS_DEF;

	// Scoreboard: mirrors the time counter and the sorted list, queues predicted results
	class alarm_scoreboard;
		logic [63:0]       now_ticks;
		logic [ID_W-1:0]   slot_id [MAX_SLOTS];
		logic [63:0]       slot_deadline [MAX_SLOTS];
		int                slot_count;
		logic [63:0]       period [NUM_IDS];
		bit                periodic [NUM_IDS];
		bit                armed [NUM_IDS];
		smas_pkg::result_t expected_q [$];
		int                errors;

		function new();
			now_ticks = '0;
			slot_count = 0;
			errors = 0;
			for (int k = 0; k < MAX_SLOTS; k++) begin
				slot_id[k] = '0;
				slot_deadline[k] = '0;
			end
			for (int k = 0; k < NUM_IDS; k++) begin
				period[k] = '0;
				periodic[k] = 1'b0;
				armed[k] = 1'b0;
			end
		endfunction

		// Take one entry out of the list, closing the gap
		function void remove_at(int pos);
			if (pos >= slot_count)
				return;
			armed[slot_id[pos]] = 1'b0;
			for (int k = pos; k + 1 < slot_count; k++) begin
				slot_id[k] = slot_id[k + 1];
				slot_deadline[k] = slot_deadline[k + 1];
			end
			slot_count--;
		endfunction

		function void unlink_entry(logic [ID_W-1:0] id);
			if (!armed[id])
				return;
			for (int k = 0; k < slot_count; k++) begin
				if (slot_id[k] == id) begin
					remove_at(k);
					return;
				end
			end
			armed[id] = 1'b0;
		endfunction

		// Insert ahead of any entry with an equal deadline
		function void place_entry(logic [ID_W-1:0] id, logic [63:0] deadline);
			int pos;
			pos = 0;
			if (slot_count >= MAX_SLOTS)
				return;
			while (pos < slot_count && deadline > slot_deadline[pos])
				pos++;
			for (int k = slot_count; k > pos; k--) begin
				slot_id[k] = slot_id[k - 1];
				slot_deadline[k] = slot_deadline[k - 1];
			end
			slot_id[pos] = id;
			slot_deadline[pos] = deadline;
			slot_count++;
			armed[id] = 1'b1;
		endfunction

		// Called once per accepted item
		function void note_item(smas_pkg::item_t it);
			smas_pkg::result_t r;
			logic [ID_W-1:0]   head;
			r = '0;
			case (it.operation)
				smas_pkg::OP_TICK: begin
					now_ticks = now_ticks + 64'd1;
					if (slot_count > 0 && slot_deadline[0] <= now_ticks) begin
						head = slot_id[0];
						remove_at(0);
						r.fired = 1'b1;
						r.fired_alarm = head;
						if (periodic[head])
							place_entry(head, now_ticks + period[head]);
					end
				end
				smas_pkg::OP_ARM: begin
					unlink_entry(it.alarm_id);
					period[it.alarm_id] = it.interval_clocks;
					periodic[it.alarm_id] = it.repeat_req;
					if (slot_count >= MAX_SLOTS)
						r.status = 1'b1;
					else
						place_entry(it.alarm_id, now_ticks + it.interval_clocks);
				end
				smas_pkg::OP_CANCEL: begin
					unlink_entry(it.alarm_id);
				end
				default: begin
				end
			endcase
			r.active_count = 5'(slot_count);
			r.next_deadline = (slot_count > 0) ? slot_deadline[0] : '0;
			expected_q.push_back(r);
		endfunction

		function void mismatch(string field, logic [63:0] want, logic [63:0] got);
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
			errors++;
		endfunction

		// Called for every result strobe
		function void check_result(smas_pkg::result_t got);
			smas_pkg::result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected: actual %p", $time, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.fired !== want.fired)
				mismatch("fired", want.fired, got.fired);
			if (got.fired_alarm !== want.fired_alarm)
				mismatch("fired_alarm", want.fired_alarm, got.fired_alarm);
			if (got.status !== want.status)
				mismatch("status", want.status, got.status);
			if (got.active_count !== want.active_count)
				mismatch("active_count", want.active_count, got.active_count);
			if (got.next_deadline !== want.next_deadline)
				mismatch("next_deadline", want.next_deadline, got.next_deadline);
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	smas_pkg::item_t   item;
	logic              done;
	smas_pkg::result_t result;

	alarm_scoreboard sb;
	int              idle_pct;
	int              cycle_count;

	sorted_multi_alarm_scheduler uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	// Clock, period 12
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// Run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles", $time, cycle_count);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic smas_pkg::item_t make_item(logic [1:0] op, logic [ID_W-1:0] id,
			logic [63:0] ivl, logic rep);
		smas_pkg::item_t it;
		it.operation = op;
		it.alarm_id = id;
		it.interval_clocks = ivl;
		it.repeat_req = rep;
		return it;
	endfunction

	// Mostly short intervals so alarms fire; some full-width and some that wrap
	function automatic logic [63:0] random_interval();
		int pick;
		pick = $urandom_range(99);
		if (pick < 60)
			return 64'($urandom_range(20));
		else if (pick < 80)
			return 64'($urandom_range(200));
		else if (pick < 90)
			return {$urandom, $urandom};
		else
			return 64'd0 - 64'($urandom_range(30));
	endfunction

	function automatic smas_pkg::item_t random_item();
		smas_pkg::item_t it;
		int              pick;
		pick = $urandom_range(99);
		if (pick < 50)
			it.operation = smas_pkg::OP_TICK;
		else if (pick < 80)
			it.operation = smas_pkg::OP_ARM;
		else if (pick < 94)
			it.operation = smas_pkg::OP_CANCEL;
		else
			it.operation = smas_pkg::OP_NOP;
		it.alarm_id = ID_W'($urandom_range(NUM_IDS - 1));
		it.interval_clocks = random_interval();
		it.repeat_req = 1'($urandom_range(1));
		return it;
	endfunction

	// Present one item, with an optional idle gap first, and hold it until taken
	task automatic drive_item(smas_pkg::item_t it);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		sb.note_item(it);
	endtask

	// Hold the sender off until every expected result is back
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	initial begin
		int              sent;
		int              off;
		bit              drained_mid;
		smas_pkg::item_t it;

		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		idle_pct = 28;
		drained_mid = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ignored op, cancel of an idle alarm, empty tick
		drive_item(make_item(smas_pkg::OP_NOP, 4'd15, '1, 1'b1));
		drive_item(make_item(smas_pkg::OP_CANCEL, 4'd5, '0, 1'b0));
		drive_item(make_item(smas_pkg::OP_TICK, 4'd0, '0, 1'b0));
		// zero interval fires on the next tick
		drive_item(make_item(smas_pkg::OP_ARM, 4'd0, 64'd0, 1'b0));
		drive_item(make_item(smas_pkg::OP_TICK, 4'd0, '0, 1'b0));
		// largest interval wraps past zero and is already due
		drive_item(make_item(smas_pkg::OP_ARM, 4'd15, '1, 1'b0));
		drive_item(make_item(smas_pkg::OP_TICK, 4'd15, '1, 1'b1));
		// equal deadlines: the later arm goes first
		drive_item(make_item(smas_pkg::OP_ARM, 4'd2, 64'd3, 1'b1));
		drive_item(make_item(smas_pkg::OP_ARM, 4'd3, 64'd3, 1'b0));
		drive_item(make_item(smas_pkg::OP_TICK, 4'd0, '0, 1'b0));
		drive_item(make_item(smas_pkg::OP_TICK, 4'd0, '0, 1'b0));
		drive_item(make_item(smas_pkg::OP_TICK, 4'd0, '0, 1'b0));
		drive_item(make_item(smas_pkg::OP_TICK, 4'd0, '0, 1'b0));
		// re-arm of an active periodic alarm, then cancel it
		drive_item(make_item(smas_pkg::OP_ARM, 4'd2, 64'd5, 1'b1));
		drive_item(make_item(smas_pkg::OP_CANCEL, 4'd2, '0, 1'b0));
		// periodic with zero interval fires every tick
		drive_item(make_item(smas_pkg::OP_ARM, 4'd7, 64'd0, 1'b1));
		drive_item(make_item(smas_pkg::OP_TICK, 4'd0, '0, 1'b0));
		drive_item(make_item(smas_pkg::OP_TICK, 4'd0, '0, 1'b0));
		drive_item(make_item(smas_pkg::OP_CANCEL, 4'd7, '0, 1'b0));
		// full-width interval with every bit set in a pattern
		drive_item(make_item(smas_pkg::OP_ARM, 4'd10, 64'hA5A5_5A5A_F0F0_0F0F, 1'b1));
		drive_item(make_item(smas_pkg::OP_ARM, 4'd11, 64'h5A5A_A5A5_0F0F_F0F0, 1'b0));
		drive_item(make_item(smas_pkg::OP_NOP, 4'd0, '0, 1'b0));
		wait_drained();

		// Random part: mixed items, with bursts that fill the whole list
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			idle_pct = (sent >= 700 && sent < 1100) ? 0 : 28;
			if (!drained_mid && sent >= 1300) begin
				wait_drained();
				drained_mid = 1'b1;
			end
			if ($urandom_range(99) < 4) begin
				off = $urandom_range(NUM_IDS - 1);
				for (int k = 0; k < NUM_IDS; k++)
					drive_item(make_item(smas_pkg::OP_ARM, ID_W'((k + off) % NUM_IDS),
						random_interval(), 1'($urandom_range(1))));
				sent += NUM_IDS;
			end else begin
				it = random_item();
				drive_item(it);
				sent++;
			end
		end
		start <= 1'b0;

		// Drain
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
